### rtl/core/rctp_pkg.sv
// ----------------------------------------------------------------------------
// rctp_pkg
// Shared types and constants of the RGB color text parser: the transfer
// payloads, the character classes and the parser state codes.
// ----------------------------------------------------------------------------
package rctp_pkg;

    localparam int RCTP_QUEUE_DEPTH = 2;

    localparam logic [7:0]  CH_HASH      = 8'h23;
    localparam logic [7:0]  CH_SPACE     = 8'h20;
    localparam logic [7:0]  CH_MINUS     = 8'h2D;
    localparam logic [11:0] MAX_COMP_VAL = 12'd255;
    localparam logic [2:0]  HEX_LONG     = 3'd6;
    localparam logic [2:0]  HEX_SHORT    = 3'd3;
    localparam logic [2:0]  HEX_OVER     = 3'd7;
    localparam logic [1:0]  NUM_COMP     = 2'd3;
    localparam logic [1:0]  LAST_COMP    = 2'd2;

    typedef struct packed {
        logic [7:0] char_code;
        logic       has_char;
        logic       last;
    } t_in;

    typedef struct packed {
        logic       ok;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_out;

    typedef enum logic [2:0] {
        K_HASH,
        K_SPACE,
        K_MINUS,
        K_DIGIT,
        K_HEXLET,
        K_OTHER
    } t_kind;

    // One classified character as it waits between front and back.
    typedef struct packed {
        t_kind      kind;
        logic [3:0] nib;
        logic       has_char;
        logic       last;
    } t_item;

    typedef enum logic [1:0] {
        M_START,
        M_HEX,
        M_DEC,
        M_FAIL
    } t_mode;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_MINUS,
        PH_NEGZERO,
        PH_DIGITS
    } t_phase;

endpackage

### rtl/core/rctp_front.sv
// ----------------------------------------------------------------------------
// rctp_front
// Input side: takes character transfers and classifies each byte into a
// character kind and a 4-bit digit value for the parser queue.
// ----------------------------------------------------------------------------
module rctp_front (
    input  rctp_pkg::t_in   i_in,
    input  logic            i_in_valid,
    input  logic            i_full,
    output logic            o_in_stall,
    output logic            o_push,
    output rctp_pkg::t_item o_item
);
    import rctp_pkg::*;

    logic [7:0] c;

    assign c          = i_in.char_code;
    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

    always_comb begin
        o_item.has_char = i_in.has_char;
        o_item.last     = i_in.last;
        o_item.nib      = c[3:0];
        if (c == CH_HASH) begin
            o_item.kind = K_HASH;
        end else if (c == CH_SPACE) begin
            o_item.kind = K_SPACE;
        end else if (c == CH_MINUS) begin
            o_item.kind = K_MINUS;
        end else if (c inside {[8'h30:8'h39]}) begin
            o_item.kind = K_DIGIT;
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            // Letters a-f and A-F both have 1..6 in the low nibble.
            o_item.kind = K_HEXLET;
            o_item.nib  = c[3:0] + 4'd9;
        end else begin
            o_item.kind = K_OTHER;
        end
    end

endmodule

### rtl/core/rctp_queue.sv
// ----------------------------------------------------------------------------
// rctp_queue
// Short first-in first-out queue of classified characters between the
// input side and the parser.
// ----------------------------------------------------------------------------
module rctp_queue #(
    parameter int DEPTH = rctp_pkg::RCTP_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rctp_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output rctp_pkg::t_item o_item
);
    import rctp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item         r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wr_ptr;
    logic [AW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### rtl/core/rctp_back.sv
// ----------------------------------------------------------------------------
// rctp_back
// Parser: steps the hex or decimal state machine by one classified character
// a cycle (not a last one while stalled); the output register holds the color.
// ----------------------------------------------------------------------------
module rctp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  rctp_pkg::t_item i_q_item,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output rctp_pkg::t_out  o_out
);
    import rctp_pkg::*;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] val;
        logic       fail;
    } t_start;

    t_mode       r_mode;
    logic [2:0]  r_hcnt;
    logic [23:0] r_nib;
    logic [1:0]  r_cidx;
    t_phase      r_phase;
    logic [7:0]  r_val;
    logic [7:0]  r_store [3];
    logic        r_out_valid;
    t_out        r_out;

    t_mode       s_mode;
    logic [2:0]  s_hcnt;
    logic [23:0] s_nib;
    logic [1:0]  s_cidx;
    t_phase      s_phase;
    logic [7:0]  s_val;
    logic [7:0]  s_store [3];

    t_mode       n_mode;
    logic [2:0]  n_hcnt;
    logic [23:0] n_nib;
    logic [1:0]  n_cidx;
    t_phase      n_phase;
    logic [7:0]  n_val;
    logic [7:0]  n_store [3];
    logic        n_out_valid;
    t_out        res;

    logic        is_digit;
    logic        is_zero;
    logic        is_hex;
    logic [11:0] dec_acc;
    t_start      st;
    logic        take_last;

    // Action for a character at a point where a number may begin.
    function automatic t_start start_char(input t_kind kind, input logic [3:0] nib);
        t_start s;
        s.phase = PH_SKIP;
        s.val   = 8'd0;
        s.fail  = 1'b0;
        case (kind)
            K_SPACE: s.phase = PH_SKIP;
            K_MINUS: s.phase = PH_MINUS;
            K_DIGIT: begin
                s.phase = PH_DIGITS;
                s.val   = {4'd0, nib};
            end
            default: s.fail = 1'b1;
        endcase
        return s;
    endfunction

    // A finished color may only leave when the output register is free.
    assign o_pop = i_q_valid && (!i_q_item.last || !r_out_valid || !i_out_stall);
    assign take_last   = o_pop && i_q_item.last;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign is_digit = (i_q_item.kind == K_DIGIT);
    assign is_zero  = is_digit && (i_q_item.nib == 4'd0);
    assign is_hex   = is_digit || (i_q_item.kind == K_HEXLET);
    assign dec_acc  = {1'b0, r_val, 3'b000} + {3'b000, r_val, 1'b0}
                    + {8'd0, i_q_item.nib};
    assign st       = start_char(i_q_item.kind, i_q_item.nib);

    // Effect of one character on the parse state.
    always_comb begin : step
        s_mode  = r_mode;
        s_hcnt  = r_hcnt;
        s_nib   = r_nib;
        s_cidx  = r_cidx;
        s_phase = r_phase;
        s_val   = r_val;
        s_store = r_store;
        if (o_pop && i_q_item.has_char) begin
            if (r_mode == M_START && i_q_item.kind == K_HASH) begin
                s_mode = M_HEX;
            end else if (r_mode == M_START || r_mode == M_DEC) begin
                s_mode = M_DEC;
                if (r_cidx != NUM_COMP) begin
                    case (r_phase)
                        PH_SKIP: begin
                            s_phase = st.phase;
                            s_val   = st.val;
                            if (st.fail) begin
                                s_mode = M_FAIL;
                            end
                        end
                        PH_MINUS: begin
                            if (is_zero) begin
                                s_phase = PH_NEGZERO;
                            end else begin
                                s_mode = M_FAIL;
                            end
                        end
                        PH_NEGZERO: begin
                            if (is_zero) begin
                                s_phase = PH_NEGZERO;
                            end else if (is_digit) begin
                                s_mode = M_FAIL;
                            end else begin
                                s_store[r_cidx] = 8'd0;
                                s_cidx  = r_cidx + 1'b1;
                                s_phase = PH_SKIP;
                                s_val   = 8'd0;
                                if (r_cidx != LAST_COMP) begin
                                    s_phase = st.phase;
                                    s_val   = st.val;
                                    if (st.fail) begin
                                        s_mode = M_FAIL;
                                    end
                                end
                            end
                        end
                        default: begin
                            if (is_digit) begin
                                if (dec_acc > MAX_COMP_VAL) begin
                                    s_mode = M_FAIL;
                                end else begin
                                    s_val = dec_acc[7:0];
                                end
                            end else begin
                                s_store[r_cidx] = r_val;
                                s_cidx  = r_cidx + 1'b1;
                                s_phase = PH_SKIP;
                                s_val   = 8'd0;
                                if (r_cidx != LAST_COMP) begin
                                    s_phase = st.phase;
                                    s_val   = st.val;
                                    if (st.fail) begin
                                        s_mode = M_FAIL;
                                    end
                                end
                            end
                        end
                    endcase
                end
            end else if (r_mode == M_HEX) begin
                if (!is_hex) begin
                    s_mode = M_FAIL;
                end else if (r_hcnt >= HEX_LONG) begin
                    s_hcnt = HEX_OVER;
                end else begin
                    s_nib  = {r_nib[19:0], i_q_item.nib};
                    s_hcnt = r_hcnt + 1'b1;
                end
            end
        end
    end

    // Next state: the parser starts over after the last character of a text.
    always_comb begin : next_state
        n_mode  = s_mode;
        n_hcnt  = s_hcnt;
        n_nib   = s_nib;
        n_cidx  = s_cidx;
        n_phase = s_phase;
        n_val   = s_val;
        n_store = s_store;
        if (take_last) begin
            n_mode     = M_START;
            n_hcnt     = 3'd0;
            n_nib      = 24'd0;
            n_cidx     = 2'd0;
            n_phase    = PH_SKIP;
            n_val      = 8'd0;
            n_store[0] = 8'd0;
            n_store[1] = 8'd0;
            n_store[2] = 8'd0;
        end
        n_out_valid = take_last || (r_out_valid && i_out_stall);
    end

    // Result of the text that ends with the current character.
    always_comb begin : outputs
        res = '0;
        case (s_mode)
            M_HEX: begin
                if (s_hcnt == HEX_LONG) begin
                    res = '{ok: 1'b1, red: s_nib[23:16], green: s_nib[15:8],
                             blue: s_nib[7:0]};
                end else if (s_hcnt == HEX_SHORT) begin
                    res = '{ok: 1'b1, red: {2{s_nib[11:8]}},
                             green: {2{s_nib[7:4]}}, blue: {2{s_nib[3:0]}}};
                end
            end
            M_DEC: begin
                if (s_cidx == LAST_COMP &&
                    (s_phase == PH_DIGITS || s_phase == PH_NEGZERO)) begin
                    res = '{ok: 1'b1, red: s_store[0], green: s_store[1],
                             blue: (s_phase == PH_NEGZERO) ? 8'd0 : s_val};
                end else if (s_cidx == NUM_COMP) begin
                    res = '{ok: 1'b1, red: s_store[0], green: s_store[1],
                             blue: s_store[2]};
                end
            end
            default: res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_START;
            r_hcnt      <= 3'd0;
            r_nib       <= 24'd0;
            r_cidx      <= 2'd0;
            r_phase     <= PH_SKIP;
            r_val       <= 8'd0;
            r_store[0]  <= 8'd0;
            r_store[1]  <= 8'd0;
            r_store[2]  <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_hcnt      <= n_hcnt;
            r_nib       <= n_nib;
            r_cidx      <= n_cidx;
            r_phase     <= n_phase;
            r_val       <= n_val;
            r_store     <= n_store;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_last) begin
            r_out <= res;
        end
    end

`ifndef ASSERT_OFF
    a_reset_after_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_last |=> (r_mode == M_START && r_hcnt == 3'd0 && r_cidx == 2'd0))
        else $error("parser state not cleared after end of text");

    a_fail_zero_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.ok) |->
            (r_out.red == 8'd0 && r_out.green == 8'd0 && r_out.blue == 8'd0))
        else $error("failed parse carries a nonzero color");

    a_done_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cidx == NUM_COMP) |-> (r_phase == PH_SKIP && r_mode != M_HEX))
        else $error("number phase active after the third component");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !take_last)
        else $error("result register overwritten while stalled");
`endif

endmodule

### rtl/core/rgb_color_text_parser.sv
// ----------------------------------------------------------------------------
// rgb_color_text_parser
// Parses an RGB color text, "#RGB", "#RRGGBB" or three decimal numbers,
// one character per transfer, and gives one color result per text.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) carries one character per
//   transfer; has_char = 0 carries no character, last = 1 ends the text.
//   Output channel (o_out_valid / i_out_stall / o_out) carries one result
//   per text: ok and the red, green and blue bytes, all zero when ok = 0.
//   Throughput: one character per cycle; the parser state machine takes one
//   queued character each cycle unless it is a last character held by a stall.
//   Result path: the text's last character is written into the queue, and the
//   parser loads the result into the output register when it takes that
//   character from the queue.
//   A queue of QUEUE_DEPTH classified characters sits between the input
//   classifier and the parser; o_in_stall rises only when it is full.
//   When the receiver stalls, the result holds in the output register and
//   the parser keeps consuming characters until it reaches the next last
//   character, which then waits in the queue.
//   Reset (synchronous, active low) empties the queue, drops any held result
//   and returns the parser to the start of a text.
// ----------------------------------------------------------------------------
module rgb_color_text_parser #(
    parameter int QUEUE_DEPTH = rctp_pkg::RCTP_QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  rctp_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output rctp_pkg::t_out o_out
);
    import rctp_pkg::*;

    logic  push;
    logic  pop;
    logic  full;
    logic  q_valid;
    t_item front_item;
    t_item q_item;

    rctp_front u_front (
        .i_in       (i_in),
        .i_in_valid (i_in_valid),
        .i_full     (full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_item     (front_item)
    );

    rctp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    rctp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

### bench/rgb_color_text_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_color_text_parser_tb
// Sends color texts one character per transfer: hex and decimal colors,
// malformed and random texts, empty texts and items that carry no character.
// A predictor in the bench works out each expected color, and every result
// is compared field by field. The input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module rgb_color_text_parser_tb;
    import rctp_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 10;
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 600000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_in  in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_item;

    rgb_color_text_parser dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Predictor state for the text in progress.
    t_mode      txt_mode;
    logic [2:0] hex_count;
    logic [23:0] hex_bits;
    logic [1:0] comp_idx;
    t_phase     num_phase;
    logic [8:0] num_val;
    logic [7:0] comp_val [0:2];

    t_out       pending_colors[$];
    logic [7:0] text_buf[$];

    int  error_count = 0;
    int  items_sent = 0;
    int  texts_sent = 0;
    int  colors_checked = 0;
    int  colors_ok = 0;
    int  cycle_count = 0;
    int  stall_left = 0;
    bit  gaps_on = 1'b1;
    bit  stalls_on = 1'b1;

    function automatic void reset_parser();
        txt_mode  = M_START;
        hex_count = '0;
        hex_bits  = '0;
        comp_idx  = '0;
        num_phase = PH_SKIP;
        num_val   = '0;
        for (int i = 0; i < 3; i++) comp_val[i] = '0;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Returns {valid, value} of a hex digit in either case.
    function automatic logic [4:0] hex_nibble(logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (is_digit(c)) return {1'b1, c[3:0]};
        if (c >= "a" && c <= "f") begin
            v = c - "a" + 8'd10;
            return {1'b1, v[3:0]};
        end
        if (c >= "A" && c <= "F") begin
            v = c - "A" + 8'd10;
            return {1'b1, v[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic void close_number();
        if (comp_idx < NUM_COMP) comp_val[comp_idx] = num_val[7:0];
        comp_idx  = comp_idx + 2'd1;
        num_phase = PH_SKIP;
        num_val   = '0;
    endfunction

    // A character at a place where a number may begin.
    function automatic void begin_number(logic [7:0] c);
        if (c == CH_SPACE) return;
        if (c == CH_MINUS) begin
            num_phase = PH_MINUS;
        end else if (is_digit(c)) begin
            num_phase = PH_DIGITS;
            num_val   = 9'(c - "0");
        end else begin
            txt_mode = M_FAIL;
        end
    endfunction

    function automatic void decimal_char(logic [7:0] c);
        logic [11:0] v;
        v = '0;
        if (comp_idx >= NUM_COMP) return;
        case (num_phase)
            PH_SKIP: begin
                begin_number(c);
            end
            PH_MINUS: begin
                if (c == "0") num_phase = PH_NEGZERO;
                else txt_mode = M_FAIL;
            end
            PH_NEGZERO: begin
                if (c != "0") begin
                    if (is_digit(c)) begin
                        txt_mode = M_FAIL;
                    end else begin
                        num_val = '0;
                        close_number();
                        if (comp_idx < NUM_COMP) begin_number(c);
                    end
                end
            end
            default: begin
                if (is_digit(c)) begin
                    v = 12'(num_val * 10 + (c - "0"));
                    if (v > MAX_COMP_VAL) txt_mode = M_FAIL;
                    else num_val = v[8:0];
                end else begin
                    close_number();
                    if (comp_idx < NUM_COMP) begin_number(c);
                end
            end
        endcase
    endfunction

    function automatic void hex_char(logic [7:0] c);
        logic [4:0] h;
        h = hex_nibble(c);
        if (!h[4]) begin
            txt_mode = M_FAIL;
        end else if (hex_count >= HEX_LONG) begin
            hex_count = HEX_OVER;
        end else begin
            hex_bits  = {hex_bits[19:0], h[3:0]};
            hex_count = hex_count + 3'd1;
        end
    endfunction

    // Advances the predictor by one item; returns 1 with the color on the last one.
    function automatic bit predict_color(input t_in it, output t_out res);
        res = '0;
        if (it.has_char) begin
            case (txt_mode)
                M_START: begin
                    if (it.char_code == CH_HASH) begin
                        txt_mode = M_HEX;
                    end else begin
                        txt_mode = M_DEC;
                        decimal_char(it.char_code);
                    end
                end
                M_HEX:   hex_char(it.char_code);
                M_DEC:   decimal_char(it.char_code);
                default: ;
            endcase
        end
        if (!it.last) return 1'b0;

        if (txt_mode == M_HEX) begin
            if (hex_count == HEX_LONG) begin
                res.ok    = 1'b1;
                res.red   = hex_bits[23:16];
                res.green = hex_bits[15:8];
                res.blue  = hex_bits[7:0];
            end else if (hex_count == HEX_SHORT) begin
                res.ok    = 1'b1;
                res.red   = {2{hex_bits[11:8]}};
                res.green = {2{hex_bits[7:4]}};
                res.blue  = {2{hex_bits[3:0]}};
            end
        end else if (txt_mode == M_DEC) begin
            // The third number may run right up to the end of the text.
            if (comp_idx == LAST_COMP &&
                (num_phase == PH_DIGITS || num_phase == PH_NEGZERO)) begin
                if (num_phase == PH_NEGZERO) num_val = '0;
                close_number();
            end
            if (comp_idx >= NUM_COMP) begin
                res.ok    = 1'b1;
                res.red   = comp_val[0];
                res.green = comp_val[1];
                res.blue  = comp_val[2];
            end
        end
        reset_parser();
        return 1'b1;
    endfunction

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_in make_item(logic [7:0] c, logic has, logic last);
        t_in it;
        it.char_code = c;
        it.has_char  = has;
        it.last      = last;
        return it;
    endfunction

    always @(posedge clk) begin
        if (!stalls_on) begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
        end else begin
            out_stall  <= ($urandom_range(0, 99) < 30);
            stall_left = idle_length();
        end
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk) begin : result_check
        t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_colors.size() == 0) begin
                error_count++;
                $display("%0t: result with none expected, actual ok=%0b rgb=%h%h%h",
                         $time, out_item.ok, out_item.red, out_item.green, out_item.blue);
            end else begin
                want = pending_colors.pop_front();
                check_field("ok", 8'(want.ok), 8'(out_item.ok));
                check_field("red", want.red, out_item.red);
                check_field("green", want.green, out_item.green);
                check_field("blue", want.blue, out_item.blue);
                colors_checked++;
                if (want.ok) colors_ok++;
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d results outstanding", $time, pending_colors.size());
        $display("rgb_color_text_parser_tb failed");
        $finish;
    end

    // Presents one item and returns at the edge of its transfer.
    task automatic send_item(input t_in it);
        int   gap;
        t_out res;
        gap = 0;
        if (gaps_on && $urandom_range(0, 99) < 40) gap = idle_length() + 1;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (predict_color(it, res)) pending_colors.push_back(res);
        if (it.has_char || it.last) items_sent++;
    endtask

    // Sends text_buf as one text; with extras, empty items may be mixed in.
    task automatic send_text(input bit extras);
        bit tail;
        int n;
        n = text_buf.size();
        tail = (n == 0) || (extras && $urandom_range(0, 19) == 0);
        for (int i = 0; i < n; i++) begin
            if (extras && $urandom_range(0, 99) < 4)
                send_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
            send_item(make_item(text_buf[i], 1'b1, !tail && i == n - 1));
        end
        if (tail) send_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
        texts_sent++;
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_colors.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endfunction

    function automatic logic [7:0] rand_hex_digit();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10) return 8'("0" + r);
        if (r < 16) return 8'("a" + r - 10);
        return 8'("A" + r - 16);
    endfunction

    function automatic void gen_hex_text();
        int r;
        int n;
        r = $urandom_range(0, 99);
        n = (r < 48) ? 3 : (r < 96) ? 6 : $urandom_range(0, 9);
        text_buf.delete();
        text_buf.push_back(CH_HASH);
        repeat (n) text_buf.push_back(rand_hex_digit());
    endfunction

    function automatic void gen_decimal_text();
        int    r;
        int    spaces;
        string s;
        text_buf.delete();
        for (int k = 0; k < 3; k++) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
                s = "";
                if ($urandom_range(0, 99) < 15) repeat ($urandom_range(1, 2)) s = {s, "0"};
                s = {s, $sformatf("%0d", $urandom_range(0, 255))};
            end else if (r < 82) begin
                s = "-0";
                repeat ($urandom_range(0, 2)) s = {s, "0"};
            end else if (r < 90) begin
                s = $sformatf("%0d", $urandom_range(256, 99999));
            end else if (r < 96) begin
                s = $sformatf("-%0d", $urandom_range(1, 255));
            end else begin
                s = ($urandom_range(0, 1) != 0) ? "-" : "+5";
            end
            spaces = ($urandom_range(0, 99) < 70) ? 1 : $urandom_range(0, 4);
            // A number that does not start with a minus needs a space before it.
            if (k > 0 && s[0] != CH_MINUS && spaces == 0) spaces = 1;
            repeat (spaces) text_buf.push_back(CH_SPACE);
            push_str(s);
        end
        if ($urandom_range(0, 99) < 25)
            repeat ($urandom_range(1, 4)) text_buf.push_back(8'($urandom_range(32, 126)));
    endfunction

    function automatic void gen_malformed_text();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 1) != 0) gen_decimal_text();
        else gen_hex_text();
        n = text_buf.size();
        if (r < 35) begin
            text_buf[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
        end else if (r < 55) begin
            text_buf.delete($urandom_range(0, n - 1));
        end else if (r < 70) begin
            while (text_buf.size() > $urandom_range(0, n - 1)) void'(text_buf.pop_back());
        end else if (r < 85) begin
            text_buf.delete();
            repeat ($urandom_range(1, 8)) text_buf.push_back(8'($urandom_range(0, 255)));
        end else if (r < 92) begin
            text_buf.delete();
            repeat ($urandom_range(1, 5)) text_buf.push_back(CH_SPACE);
        end else begin
            text_buf.delete();
        end
    endfunction

    function automatic void gen_any_text();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) gen_decimal_text();
        else if (r < 65) gen_hex_text();
        else gen_malformed_text();
    endfunction

    task automatic test_directed_cases();
        // Empty text.
        text_buf.delete();
        send_text(1'b0);
        // Short hex in mixed case, with an empty item inside.
        send_item(make_item(CH_HASH, 1'b1, 1'b0));
        send_item(make_item("a", 1'b1, 1'b0));
        send_item(make_item("F", 1'b1, 1'b0));
        send_item(make_item(8'h00, 1'b0, 1'b0));
        send_item(make_item("0", 1'b1, 1'b1));
        // Largest value, a minus zero right after it, and a plain zero.
        text_buf.delete();
        push_str("255-0 0");
        send_text(1'b0);
        // A byte of all ones is no hex digit.
        text_buf.delete();
        push_str("#1");
        text_buf.push_back(8'hFF);
        send_text(1'b0);
        text_buf.delete();
        push_str("256");
        send_text(1'b0);
        // A zero byte where a separator should stand.
        text_buf.delete();
        push_str("1");
        text_buf.push_back(8'h00);
        send_text(1'b0);
        text_buf.delete();
        push_str("-1");
        send_text(1'b0);
        wait_for_drain();
    endtask

    task automatic test_hex_texts();
        int stop_at;
        stop_at = items_sent + 350;
        while (items_sent < stop_at) begin
            gen_hex_text();
            send_text(1'b1);
        end
        wait_for_drain();
    endtask

    task automatic test_decimal_texts();
        int stop_at;
        stop_at = items_sent + 600;
        while (items_sent < stop_at) begin
            gen_decimal_text();
            send_text(1'b1);
        end
        wait_for_drain();
    endtask

    task automatic test_malformed_texts();
        int stop_at;
        stop_at = items_sent + 300;
        while (items_sent < stop_at) begin
            gen_malformed_text();
            send_text(1'b1);
        end
        wait_for_drain();
    endtask

    task automatic test_back_to_back();
        int stop_at;
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        stop_at = items_sent + 200;
        while (items_sent < stop_at) begin
            gen_any_text();
            send_text(1'b0);
        end
        wait_for_drain();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    task automatic test_mixed_traffic();
        int stop_at;
        stop_at = items_sent + 300;
        while (items_sent < stop_at) begin
            gen_any_text();
            send_text(1'b1);
            if ($urandom_range(0, 29) == 0) wait_for_drain();
        end
        wait_for_drain();
    endtask

    initial begin
        reset_parser();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_hex_texts();
        test_decimal_texts();
        test_malformed_texts();
        test_back_to_back();
        test_mixed_traffic();
        $display("Sent %0d characters and end marks in %0d texts over %0d cycles.",
                 items_sent, texts_sent, cycle_count);
        $display("Checked %0d colors, %0d of them valid, with %0d errors.",
                 colors_checked, colors_ok, error_count);
        if (error_count == 0) begin
            $display("rgb_color_text_parser_tb passed");
        end else begin
            $display("rgb_color_text_parser_tb failed");
        end
        $finish;
    end

endmodule
